@@ src/two_set_intersection_filter_top_assert.svh @@
// Assertion macros shared by the filter RTL.
`ifndef TWO_SET_INTERSECTION_FILTER_TOP_ASSERT_SVH
`define TWO_SET_INTERSECTION_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSIF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tsif_pkg.sv @@
package tsif_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_APPEND_C = 2'd2,
    CMD_FILTER   = 2'd3
  } tsif_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } tsif_state_t;

  typedef struct packed {
    logic              clear;
    logic              cmp_en;
    logic [ADDR_W-1:0] idx;
  } tsif_match_ctl_t;

endpackage

@@ src/tsif_ram.sv @@
module tsif_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/tsif_match.sv @@
module tsif_match
  import tsif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsif_match_ctl_t      ctl,
  input  logic [DATA_W-1:0]    key,
  input  logic [DATA_W-1:0]    rdata_b,
  input  logic [DATA_W-1:0]    rdata_c,
  input  logic [CNT_W-1:0]     count_b,
  input  logic [CNT_W-1:0]     count_c,
  output logic                 hit_b,
  output logic                 hit_c
);

  logic hit_b_r;
  logic hit_c_r;
  logic hit_b_nxt;
  logic hit_c_nxt;
  logic in_b;
  logic in_c;

  assign in_b = CNT_W'(ctl.idx) < count_b;
  assign in_c = CNT_W'(ctl.idx) < count_c;

  always_comb begin
    hit_b_nxt = hit_b_r;
    hit_c_nxt = hit_c_r;
    if (ctl.clear) begin
      hit_b_nxt = 1'b0;
      hit_c_nxt = 1'b0;
    end else if (ctl.cmp_en) begin
      hit_b_nxt = hit_b_r | (in_b & (rdata_b == key));
      hit_c_nxt = hit_c_r | (in_c & (rdata_c == key));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_b_r <= 1'b0;
      hit_c_r <= 1'b0;
    end else begin
      hit_b_r <= hit_b_nxt;
      hit_c_r <= hit_c_nxt;
    end
  end

  assign hit_b = hit_b_r;
  assign hit_c = hit_c_r;

endmodule

@@ src/two_set_intersection_filter_top.sv @@
// Channel   Ports                                   Handshake
// input     in_cmd, in_value                        start high while busy low
// result    out_echo_value, out_keep, out_status    out_valid strobe, one cycle
//
// Clear and append commands never raise busy; the result strobes in the next cycle
// and a new beat is accepted at once. A filter beat scans both tables side by side
// through one registered RAM read port each, one entry per cycle, with busy high through
// the S_SCAN, S_WAIT and S_DONE states; the result strobes as busy falls. When both
// tables are empty, a filter skips the scan and its result strobes in the next cycle.
// Reset is synchronous and active low; it empties both tables. The receiver cannot stall.
`include "two_set_intersection_filter_top_assert.svh"

module two_set_intersection_filter_top
  import tsif_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_echo_value,
  output logic                     out_keep,
  output logic                     out_status
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  tsif_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_b_r, count_b_nxt;
  logic [CNT_W-1:0]  count_c_r, count_c_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] pidx_r;
  logic              pend_r;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] echo_r, echo_nxt;
  logic              keep_r, keep_nxt;
  logic              status_r, status_nxt;
  logic              we_b;
  logic              we_c;
  logic              match_clear;
  logic [CNT_W-1:0]  max_cnt;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] rdata_c;
  logic              hit_b;
  logic              hit_c;
  tsif_match_ctl_t   mctl;

  assign max_cnt = (count_b_r > count_c_r) ? count_b_r : count_c_r;

  tsif_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (idx_r),
    .rdata (rdata_b)
  );

  tsif_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (count_c_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (idx_r),
    .rdata (rdata_c)
  );

  assign mctl.clear  = match_clear;
  assign mctl.cmp_en = pend_r;
  assign mctl.idx    = pidx_r;

  tsif_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .key     (value_r),
    .rdata_b (rdata_b),
    .rdata_c (rdata_c),
    .count_b (count_b_r),
    .count_c (count_c_r),
    .hit_b   (hit_b),
    .hit_c   (hit_c)
  );

  always_comb begin
    state_nxt     = state_r;
    count_b_nxt   = count_b_r;
    count_c_nxt   = count_c_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    echo_nxt      = echo_r;
    keep_nxt      = keep_r;
    status_nxt    = status_r;
    we_b          = 1'b0;
    we_c          = 1'b0;
    match_clear   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt  = in_value;
          echo_nxt   = in_value;
          keep_nxt   = 1'b0;
          status_nxt = 1'b0;
          case (tsif_cmd_t'(in_cmd))
            CMD_CLEAR: begin
              count_b_nxt   = '0;
              count_c_nxt   = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_APPEND_B: begin
              if (count_b_r == FULL) begin
                status_nxt = 1'b1;
              end else begin
                we_b        = 1'b1;
                count_b_nxt = count_b_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            CMD_APPEND_C: begin
              if (count_c_r == FULL) begin
                status_nxt = 1'b1;
              end else begin
                we_c        = 1'b1;
                count_c_nxt = count_c_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            CMD_FILTER: begin
              match_clear = 1'b1;
              idx_nxt     = '0;
              if (max_cnt == '0) begin
                keep_nxt      = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                lim_nxt   = max_cnt;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (CNT_W'(idx_r) + CNT_W'(1) == lim_r) begin
          state_nxt = S_WAIT;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        keep_nxt      = ~(hit_b & hit_c);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_b_r   <= '0;
      count_c_r   <= '0;
      lim_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_b_r   <= count_b_nxt;
      count_c_r   <= count_c_nxt;
      lim_r       <= lim_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= idx_r;
    value_r  <= value_nxt;
    echo_r   <= echo_nxt;
    keep_r   <= keep_nxt;
    status_r <= status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_echo_value = echo_r;
  assign out_keep       = keep_r;
  assign out_status     = status_r;

  `TSIF_ASSERT_SAME(a_count_b_bound, 1'b1, count_b_r <= FULL, "count_b exceeds table depth")
  `TSIF_ASSERT_SAME(a_count_c_bound, 1'b1, count_c_r <= FULL, "count_c exceeds table depth")
  `TSIF_ASSERT_NEXT(a_done_strobe, state_r == S_DONE, out_valid_r && !busy, "no result after scan")
  `TSIF_ASSERT_SAME(a_scan_in_range, state_r == S_SCAN, CNT_W'(idx_r) < lim_r, "scan index past limit")

endmodule
